>>> rtl/iell_pkg.sv
// Shared types, codes and constants for the interleaved ELL sparse matrix-vector block.
package iell_pkg;

  // Default sizes handed to the top level.
  localparam int DEF_NUM_LANES    = 4;
  localparam int DEF_VECTOR_DEPTH = 4096;

  // Fixed field widths.
  localparam int ADDR_W  = 12;
  localparam int WORD_W  = 32;
  localparam int SUM_W   = 48;
  localparam int ROW_W   = 20;
  localparam int POS_W   = 13;
  localparam int WIDTH_W = 11;
  localparam int PROD_W  = 64;

  // Row width limits.
  localparam logic [WIDTH_W-1:0] WIDTH_MIN = 11'd1;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = 11'd1024;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_MAX_COL_WIDTH = 1'b0;

  // Opcodes of an input request.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ELEM = 1'b1;

  // Input request payload.
  typedef struct packed {
    logic                     opcode;
    logic [ADDR_W-1:0]        vec_addr;
    logic signed [WORD_W-1:0] vec_value;
    logic [ADDR_W-1:0]        col_index;
    logic signed [WORD_W-1:0] mat_value;
  } iell_in_t;

  // Result request payload.
  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic signed [SUM_W-1:0] row_sum;
    logic                    last;
  } iell_out_t;

  // Control that travels with a matrix element down the multiply pipeline.
  typedef struct packed {
    logic valid;
    logic blk_end;
    logic vec_ok;
  } iell_elem_ctl_t;

endpackage

>>> rtl/iell_vec_store.sv
// Dense vector store: one write port and one registered read port.
module iell_vec_store #(
  parameter int DEPTH = iell_pkg::DEF_VECTOR_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [iell_pkg::WORD_W-1:0]   wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [iell_pkg::WORD_W-1:0]   rd_data
);
  import iell_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  // Write and read in the same clocked block; the read data is registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/iell_mac_lanes.sv
// Multiply stage and per-lane saturating accumulators.
module iell_mac_lanes #(
  parameter int NUM_LANES = iell_pkg::DEF_NUM_LANES,
  parameter int LW        = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  iell_pkg::iell_elem_ctl_t                    elem_ctl,
  input  logic [LW-1:0]                               elem_lane,
  input  logic signed [iell_pkg::WORD_W-1:0]          elem_mat,
  input  logic [iell_pkg::WORD_W-1:0]                 vec_rdata,
  input  logic                                        buf_free,
  output logic                                        hold,
  output logic                                        flush,
  output logic [NUM_LANES-1:0][iell_pkg::SUM_W-1:0]   snap_sums
);
  import iell_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  iell_elem_ctl_t            s1_ctl_r;
  logic [LW-1:0]             s1_lane_r;
  logic signed [WORD_W-1:0]  s1_mat_r;
  iell_elem_ctl_t            s2_ctl_r;
  logic [LW-1:0]             s2_lane_r;
  logic signed [PROD_W-1:0]  s2_prod_r;
  logic [SUM_W-1:0]          lane_sums_r [NUM_LANES];

  logic signed [WORD_W-1:0]  vec_val;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [SUM_W-1:0]   acc_cur;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_sat;

  // A finished block waits in the last stage while the result buffer is still busy.
  assign hold  = s2_ctl_r.valid && s2_ctl_r.blk_end && !buf_free;
  assign flush = s2_ctl_r.valid && s2_ctl_r.blk_end && !hold;

  // Product of matrix value and vector entry; an out-of-range column reads zero.
  always_comb begin
    vec_val  = s1_ctl_r.vec_ok ? $signed(vec_rdata) : '0;
    prod_nxt = PROD_W'(s1_mat_r) * PROD_W'(vec_val);
  end

  // Add the Q32.32 product, floor-shifted to Q32.16, to the lane sum and saturate.
  always_comb begin
    acc_cur  = $signed(lane_sums_r[s2_lane_r]);
    sum_wide = {acc_cur[SUM_W-1], acc_cur} + {s2_prod_r[PROD_W-1], s2_prod_r[PROD_W-1:16]};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  // Snapshot of all lanes with the closing element already added.
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      if (LW'(k) == s2_lane_r) begin
        snap_sums[k] = sum_sat;
      end else begin
        snap_sums[k] = lane_sums_r[k];
      end
    end
  end

  // Pipeline control and accumulators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      for (int k = 0; k < NUM_LANES; k++) begin
        lane_sums_r[k] <= '0;
      end
    end else if (!hold) begin
      s1_ctl_r <= elem_ctl;
      s2_ctl_r <= s1_ctl_r;
      if (s2_ctl_r.valid) begin
        if (s2_ctl_r.blk_end) begin
          for (int k = 0; k < NUM_LANES; k++) begin
            lane_sums_r[k] <= '0;
          end
        end else begin
          lane_sums_r[s2_lane_r] <= sum_sat;
        end
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (!hold) begin
      s1_lane_r <= elem_lane;
      s1_mat_r  <= elem_mat;
      s2_lane_r <= s1_lane_r;
      s2_prod_r <= prod_nxt;
    end
  end

endmodule

>>> rtl/iell_result_buf.sv
// Result buffer: holds one block of lane sums and sends them out in lane order.
module iell_result_buf #(
  parameter int NUM_LANES = iell_pkg::DEF_NUM_LANES,
  parameter int LW        = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        flush,
  input  logic [NUM_LANES-1:0][iell_pkg::SUM_W-1:0]   snap_sums,
  output logic                                        buf_free,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output iell_pkg::iell_out_t                         out_data
);
  import iell_pkg::*;

  logic                        busy_r;
  logic [LW-1:0]               cnt_r;
  logic [ROW_W-1:0]            base_row_r;
  logic [ROW_W-1:0]            out_base_r;
  logic [SUM_W-1:0]            sums_r [NUM_LANES];
  logic                        is_last;
  logic                        done;

  assign is_last   = cnt_r == LW'(NUM_LANES - 1);
  assign done      = busy_r && !out_stall && is_last;
  assign buf_free  = !busy_r || done;
  assign out_valid = busy_r;

  // Current result request.
  always_comb begin
    out_data.row_index = out_base_r + ROW_W'(cnt_r);
    out_data.row_sum   = $signed(sums_r[cnt_r]);
    out_data.last      = is_last;
  end

  // Burst control and base row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      cnt_r      <= '0;
      base_row_r <= '0;
    end else begin
      if (busy_r && !out_stall) begin
        if (is_last) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (flush) begin
        busy_r     <= 1'b1;
        cnt_r      <= '0;
        base_row_r <= base_row_r + ROW_W'(NUM_LANES);
      end
    end
  end

  // Captured sums and row base of the block being sent.
  always_ff @(posedge clk) begin
    if (flush) begin
      out_base_r <= base_row_r;
      for (int k = 0; k < NUM_LANES; k++) begin
        sums_r[k] <= snap_sums[k];
      end
    end
  end

endmodule

>>> rtl/interleaved_ell_sparse_matvec.sv
// Top level of the interleaved ELL sparse matrix-vector multiply block.
//
//   Channel  Direction  Payload      Handshake
//   in_      input      iell_in_t    in_valid / in_stall
//   out_     output     iell_out_t   out_valid / out_stall
//   cfg      input      32-bit APB   psel, penable, pwrite, pready
//
// One request is accepted per cycle while in_stall is low; an element flows through the
// vector store read, the multiply register and the accumulate register to its lane sum.
// A finished block is captured when its last element sits in the multiply register and the
// result buffer is free; it sends NUM_LANES results, one per cycle while out_stall is low.
// Input stalls only while a finished block waits for the result buffer to drain.
// Reset is synchronous: it clears sums, counters, base row and width (to 1).
// The vector store is not cleared; load entries before reading them.
module interleaved_ell_sparse_matvec #(
  parameter int NUM_LANES    = iell_pkg::DEF_NUM_LANES,
  parameter int VECTOR_DEPTH = iell_pkg::DEF_VECTOR_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  iell_pkg::iell_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output iell_pkg::iell_out_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [iell_pkg::CFG_AW-1:0]   paddr,
  input  logic [iell_pkg::CFG_DW-1:0]   pwdata,
  output logic [iell_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import iell_pkg::*;

  localparam int LW   = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
  localparam int AW   = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int BL_N = WIDTH_W + $clog2(NUM_LANES + 1);
  localparam int BL_W = (BL_N > POS_W) ? BL_N : POS_W;
  localparam logic [16:0] DEPTH_V = 17'(VECTOR_DEPTH);

  logic [WIDTH_W-1:0]  max_col_width_r;
  logic [WIDTH_W-1:0]  eff_width;
  logic [BL_W-1:0]     block_len;
  logic [POS_W-1:0]    pos_r;
  logic [POS_W-1:0]    pos_inc;
  logic [LW-1:0]       lane_r;
  logic [LW-1:0]       lane_inc;
  logic                accept;
  logic                is_elem;
  logic                blk_end;
  logic                load_ok;
  logic                col_ok;
  logic                cfg_wr;
  logic                hold;
  logic                flush;
  logic                buf_free;
  iell_elem_ctl_t      elem_ctl;
  logic [WORD_W-1:0]   vec_rdata;
  logic [NUM_LANES-1:0][SUM_W-1:0] snap_sums;

  // Configuration register access.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MAX_COL_WIDTH) ? CFG_DW'(max_col_width_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_col_width_r <= WIDTH_MIN;
    end else if (cfg_wr && (paddr[2] == REG_MAX_COL_WIDTH)) begin
      max_col_width_r <= pwdata[WIDTH_W-1:0];
    end
  end

  // Block length from the clamped row width.
  always_comb begin
    if (max_col_width_r == '0) begin
      eff_width = WIDTH_MIN;
    end else if (max_col_width_r > WIDTH_MAX) begin
      eff_width = WIDTH_MAX;
    end else begin
      eff_width = max_col_width_r;
    end
    block_len = BL_W'(eff_width) * BL_W'(NUM_LANES);
  end

  // Request acceptance and decode.
  assign in_stall = hold;
  assign accept   = in_valid && !hold;
  assign is_elem  = in_data.opcode == OP_ELEM;
  assign load_ok  = {5'b0, in_data.vec_addr} < DEPTH_V;
  assign col_ok   = {5'b0, in_data.col_index} < DEPTH_V;

  // Position within the row block and lane of the element being accepted.
  always_comb begin
    pos_inc = pos_r + 1'b1;
    blk_end = BL_W'(pos_inc) >= block_len;
    if (pos_inc == '0 || lane_r == LW'(NUM_LANES - 1)) begin
      lane_inc = '0;
    end else begin
      lane_inc = lane_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      lane_r <= '0;
    end else if (accept && is_elem) begin
      if (blk_end) begin
        pos_r  <= '0;
        lane_r <= '0;
      end else begin
        pos_r  <= pos_inc;
        lane_r <= lane_inc;
      end
    end
  end

  always_comb begin
    elem_ctl.valid   = accept && is_elem;
    elem_ctl.blk_end = blk_end;
    elem_ctl.vec_ok  = col_ok;
  end

  iell_vec_store #(
    .DEPTH (VECTOR_DEPTH),
    .AW    (AW)
  ) u_vec_store (
    .clk     (clk),
    .wr_en   (accept && !is_elem && load_ok),
    .wr_addr (AW'(in_data.vec_addr)),
    .wr_data (in_data.vec_value),
    .rd_en   (accept && is_elem),
    .rd_addr (AW'(in_data.col_index)),
    .rd_data (vec_rdata)
  );

  iell_mac_lanes #(
    .NUM_LANES (NUM_LANES),
    .LW        (LW)
  ) u_mac_lanes (
    .clk       (clk),
    .rst_n     (rst_n),
    .elem_ctl  (elem_ctl),
    .elem_lane (lane_r),
    .elem_mat  (in_data.mat_value),
    .vec_rdata (vec_rdata),
    .buf_free  (buf_free),
    .hold      (hold),
    .flush     (flush),
    .snap_sums (snap_sums)
  );

  iell_result_buf #(
    .NUM_LANES (NUM_LANES),
    .LW        (LW)
  ) u_result_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (flush),
    .snap_sums (snap_sums),
    .buf_free  (buf_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
